// ===== rtl/tlif_pkg.sv =====
// ----------------------------------------------------------------------------
// tlif_pkg
// Shared types and byte codes for the telnet line input filter: the command
// record passed from the parser front end to the echo back end.
// ----------------------------------------------------------------------------
package tlif_pkg;

  // telnet protocol bytes
  localparam logic [7:0] ByteIac  = 8'd255;
  localparam logic [7:0] ByteWill = 8'd251;
  localparam logic [7:0] ByteWont = 8'd252;
  localparam logic [7:0] ByteDo   = 8'd253;
  localparam logic [7:0] ByteDont = 8'd254;
  localparam logic [7:0] ByteEcho = 8'd1;

  // terminal and line editing bytes
  localparam logic [7:0] ByteEsc    = 8'd27;
  localparam logic [7:0] ByteDel    = 8'd127;
  localparam logic [7:0] ByteBs     = 8'd8;
  localparam logic [7:0] ByteCr     = 8'd13;
  localparam logic [7:0] ByteLf     = 8'd10;
  localparam logic [7:0] ByteSpace  = 8'd32;
  localparam logic [7:0] ByteBrack  = 8'h5B;  // '['
  localparam logic [7:0] ByteOne    = 8'h31;  // '1'
  localparam logic [7:0] ByteThree  = 8'h33;  // '3'
  localparam logic [7:0] ByteUpperO = 8'h4F;  // 'O'

  // line event codes on the result channel
  localparam logic [1:0] EvNone  = 2'd0;
  localparam logic [1:0] EvChar  = 2'd1;
  localparam logic [1:0] EvErase = 2'd2;
  localparam logic [1:0] EvEol   = 2'd3;

  // escape history depth
  localparam int unsigned HistDepth = 4;

  // command queue geometry
  localparam int unsigned QDepth = 2;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  // line length as reported on the result channel
  localparam int unsigned LenOutW = 9;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_ERASE,
    CMD_EOL
  } cmd_kind_e;

  // one classified line edit waiting for the back end
  typedef struct packed {
    cmd_kind_e            kind;
    logic [7:0]           ch;
    logic                 echo;
    logic                 peer_echo;
    logic [LenOutW-1:0]   line_len;
  } cmd_t;

endpackage

// ===== rtl/tlif_front.sv =====
// ----------------------------------------------------------------------------
// tlif_front
// Parser front end: accepts received bytes, strips telnet commands, drops
// terminal escape sequences, keeps the line length and issues one command
// per line edit into the queue.
// ----------------------------------------------------------------------------
module tlif_front
  import tlif_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  input  logic [7:0] rx_byte_i,
  output logic       in_stall_o,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned LenW = $clog2(LINE_LIMIT + 1);
  localparam logic [LenW-1:0] LenMax = LenW'(LINE_LIMIT);

  // parse phase codes
  localparam logic [1:0] PhData    = 2'd0;
  localparam logic [1:0] PhIac     = 2'd1;
  localparam logic [1:0] PhArg     = 2'd2;
  localparam logic [1:0] PhSwallow = 2'd3;

  logic [1:0]      phase_q, phase_d;
  logic [7:0]      pend_q, pend_d;
  logic            peer_q, peer_d;
  logic            hide_q;
  logic [7:0]      hist_q [HistDepth];
  logic [2:0]      hcnt_q, hcnt_d;
  logic            hist_push;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW+LenOutW-1:0] len_wide;

  logic            accept;
  logic [HistDepth-1:0] h_ok, h_esc, h_brk, h_one, h_three, h_o;
  logic            drop;
  logic            echo_chars, echo_eol;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // history entry matches; entries beyond the fill count never match
  always_comb begin
    for (int k = 0; k < HistDepth; k++) begin
      h_ok[k]    = hcnt_q > 3'(k);
      h_esc[k]   = h_ok[k] && (hist_q[k] == ByteEsc);
      h_brk[k]   = h_ok[k] && (hist_q[k] == ByteBrack);
      h_one[k]   = h_ok[k] && (hist_q[k] == ByteOne);
      h_three[k] = h_ok[k] && (hist_q[k] == ByteThree);
      h_o[k]     = h_ok[k] && (hist_q[k] == ByteUpperO);
    end
  end

  // escape sequence detection
  assign drop = (rx_byte_i == ByteEsc) || h_esc[0]
             || (h_brk[0] && h_esc[1])
             || (h_one[0] && h_brk[1] && h_esc[2])
             || (h_one[1] && h_brk[2] && h_esc[3])
             || (h_three[0] && h_brk[1] && h_esc[2])
             || (h_o[0] && h_esc[1]);

  assign echo_chars = !hide_q && !peer_q;
  assign echo_eol   = hide_q || !peer_q;

  // classification and state update
  always_comb begin
    phase_d   = phase_q;
    pend_d    = pend_q;
    peer_d    = peer_q;
    hcnt_d    = hcnt_q;
    hist_push = 1'b0;
    len_d     = len_q;
    push_o    = 1'b0;
    cmd_o.kind      = CMD_CHAR;
    cmd_o.ch        = 8'd0;
    cmd_o.echo      = 1'b0;
    cmd_o.peer_echo = peer_q;
    if (accept) begin
      unique case (phase_q)
        PhSwallow: phase_d = PhData;
        PhIac: begin
          if (rx_byte_i == ByteWill || rx_byte_i == ByteWont ||
              rx_byte_i == ByteDo || rx_byte_i == ByteDont) begin
            pend_d  = rx_byte_i;
            phase_d = PhArg;
          end else begin
            phase_d = PhData;
          end
        end
        PhArg: begin
          if (rx_byte_i == ByteEcho) begin
            if (pend_q == ByteWill) begin
              peer_d = 1'b1;
            end else if (pend_q == ByteWont) begin
              peer_d = 1'b0;
            end
          end
          phase_d = PhData;
        end
        default: begin
          if (rx_byte_i == ByteIac) begin
            phase_d = PhIac;
          end else if (drop) begin
            hist_push = 1'b1;
            if (hcnt_q < 3'(HistDepth)) begin
              hcnt_d = hcnt_q + 3'd1;
            end
          end else begin
            hcnt_d = 3'd0;
            if (rx_byte_i == ByteCr) begin
              len_d      = '0;
              phase_d    = PhSwallow;
              push_o     = 1'b1;
              cmd_o.kind = CMD_EOL;
              cmd_o.echo = echo_eol;
            end else if (rx_byte_i == ByteBs || rx_byte_i == ByteDel) begin
              if (len_q != '0) begin
                len_d      = len_q - LenW'(1);
                push_o     = 1'b1;
                cmd_o.kind = CMD_ERASE;
                cmd_o.echo = echo_chars;
              end
            end else if (len_q != LenMax) begin
              len_d      = len_q + LenW'(1);
              push_o     = 1'b1;
              cmd_o.kind = CMD_CHAR;
              cmd_o.ch   = rx_byte_i;
              cmd_o.echo = echo_chars;
            end
          end
        end
      endcase
    end
    // reported length is the low bits of the updated length
    len_wide       = (LenW + LenOutW)'(len_d);
    cmd_o.line_len = len_wide[LenOutW-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhData;
      pend_q  <= 8'd0;
      peer_q  <= 1'b1;
      hide_q  <= 1'b0;
      hcnt_q  <= 3'd0;
      len_q   <= '0;
    end else begin
      phase_q <= phase_d;
      pend_q  <= pend_d;
      peer_q  <= peer_d;
      hcnt_q  <= hcnt_d;
      len_q   <= len_d;
      if (cfg_we_i) begin
        hide_q <= cfg_wdata_i;
      end
    end
  end

  // escape history shift line, newest first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < HistDepth; k++) begin
        hist_q[k] <= 8'd0;
      end
    end else if (hist_push) begin
      hist_q[0] <= rx_byte_i;
      for (int k = 1; k < HistDepth; k++) begin
        hist_q[k] <= hist_q[k-1];
      end
    end
  end

endmodule

// ===== rtl/tlif_queue.sv =====
// ----------------------------------------------------------------------------
// tlif_queue
// Short command queue between the parser front end and the echo back end,
// so that each side can stall on its own.
// ----------------------------------------------------------------------------
module tlif_queue
  import tlif_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t head_o
);

  cmd_t             mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == QCntW'(QDepth);
  assign empty_o = cnt_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/tlif_back.sv =====
// ----------------------------------------------------------------------------
// tlif_back
// Echo back end: expands each queued command into one to three result
// transactions and holds them in an output register until taken.
// ----------------------------------------------------------------------------
module tlif_back
  import tlif_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  cmd_t               q_head_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         line_event_o,
  output logic [7:0]         char_value_o,
  output logic               tx_valid_o,
  output logic [7:0]         tx_byte_o,
  output logic               client_echoes_o,
  output logic [LenOutW-1:0] line_length_now_o,
  output logic               last_o
);

  logic [1:0] step_q, step_d;
  logic       load, gen;
  logic [1:0] ev;
  logic [7:0] chv, txb;
  logic       txv, lst;

  logic               valid_q;
  logic [1:0]         ev_q;
  logic [7:0]         chv_q, txb_q;
  logic               txv_q, lst_q, peer_q;
  logic [LenOutW-1:0] len_q;

  assign load    = !valid_q || !out_stall_i;
  assign gen     = load && !q_empty_i;
  assign q_pop_o = gen && lst;

  // result for the current step of the head command
  always_comb begin
    ev  = EvNone;
    chv = 8'd0;
    txv = 1'b1;
    txb = 8'd0;
    lst = 1'b1;
    unique case (q_head_i.kind)
      CMD_CHAR: begin
        ev  = EvChar;
        chv = q_head_i.ch;
        txv = q_head_i.echo;
        txb = q_head_i.echo ? q_head_i.ch : 8'd0;
      end
      CMD_ERASE: begin
        if (step_q == 2'd0) begin
          ev  = EvErase;
          txv = q_head_i.echo;
          txb = q_head_i.echo ? ByteBs : 8'd0;
          lst = !q_head_i.echo;
        end else if (step_q == 2'd1) begin
          txb = ByteSpace;
          lst = 1'b0;
        end else begin
          txb = ByteBs;
        end
      end
      CMD_EOL: begin
        if (step_q == 2'd0) begin
          ev  = EvEol;
          txv = q_head_i.echo;
          txb = q_head_i.echo ? ByteCr : 8'd0;
          lst = !q_head_i.echo;
        end else begin
          txb = ByteLf;
        end
      end
      default: begin
        ev  = EvNone;
        txv = 1'b0;
      end
    endcase
  end

  // step counter within one command
  always_comb begin
    step_d = step_q;
    if (gen) begin
      step_d = lst ? 2'd0 : step_q + 2'd1;
    end
  end

  // output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      step_q  <= 2'd0;
    end else begin
      step_q <= step_d;
      if (load) begin
        valid_q <= !q_empty_i;
      end
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (gen) begin
      ev_q   <= ev;
      chv_q  <= chv;
      txv_q  <= txv;
      txb_q  <= txb;
      lst_q  <= lst;
      peer_q <= q_head_i.peer_echo;
      len_q  <= q_head_i.line_len;
    end
  end

  assign out_valid_o       = valid_q;
  assign line_event_o      = ev_q;
  assign char_value_o      = chv_q;
  assign tx_valid_o        = txv_q;
  assign tx_byte_o         = txb_q;
  assign client_echoes_o   = peer_q;
  assign line_length_now_o = len_q;
  assign last_o            = lst_q;

endmodule

// ===== rtl/telnet_line_input_filter.sv =====
// ----------------------------------------------------------------------------
// telnet_line_input_filter
// Telnet line input filter: strips IAC commands and terminal escapes from the
// received byte stream, edits the current line and produces echo bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid_i / in_stall_o / rx_byte_i carries received bytes;
//   a transaction completes on a rising edge with valid high and stall low.
//   Output channel out_valid_o / out_stall_i carries result transactions
//   (line event, appended char, echo byte, echo belief, line length, last).
//   A byte that edits the line causes one to three results, the final one
//   marked by last_o; stripped, dropped or ignored bytes cause none.
//   cfg_we_i / cfg_wdata_i write hide_input; write only while idle.
//   A byte's command is queued, and its first result is then registered in
//   the output register. Throughput: one byte per cycle into the front end
//   while the queue is not full; the back end emits one result per cycle
//   while out_stall_i is low; an erase with echo gives three results.
//   A two-entry command queue lets the parser run ahead of the echo expansion.
//   Reset (rst_ni low, asynchronous): parser in data phase, client assumed
//   to echo, history and line empty, hide_input cleared, queue emptied.
//   When out_stall_i holds, the result register holds; the queue fills and
//   then in_stall_o rises until space is freed.
// ----------------------------------------------------------------------------
module telnet_line_input_filter
  import tlif_pkg::*;
#(
  parameter int unsigned LINE_LIMIT = 256
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] line_event_o,
  output logic [7:0] char_value_o,
  output logic       tx_valid_o,
  output logic [7:0] tx_byte_o,
  output logic       client_echoes_o,
  output logic [8:0] line_length_now_o,
  output logic       last_o
);

  logic q_full, q_empty, q_push, q_pop;
  cmd_t push_cmd, head_cmd;

  // parser front end
  tlif_front #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .rx_byte_i   (rx_byte_i),
    .in_stall_o  (in_stall_o),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .cmd_o       (push_cmd)
  );

  // command queue
  tlif_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_cmd)
  );

  // echo back end
  tlif_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .q_empty_i         (q_empty),
    .q_head_i          (head_cmd),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .line_event_o      (line_event_o),
    .char_value_o      (char_value_o),
    .tx_valid_o        (tx_valid_o),
    .tx_byte_o         (tx_byte_o),
    .client_echoes_o   (client_echoes_o),
    .line_length_now_o (line_length_now_o),
    .last_o            (last_o)
  );

`ifndef SYNTHESIS
  // continuation results always carry an echo byte
  a_cont_echoes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_event_o == EvNone |-> tx_valid_o)
    else $error("continuation result without echo byte");

  // a result without echo is always the final one of its byte
  a_noecho_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !tx_valid_o |-> last_o)
    else $error("non-echo result not marked last");

  // end of line reports an empty line
  a_eol_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_event_o == EvEol |-> line_length_now_o == '0)
    else $error("end of line with non-zero length");

  // no command is lost to a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("command pushed into full queue");
`endif

endmodule
